// File: hdl/sha1h_pkg.sv
// Shared types and constants for the SHA-1 byte stream hasher.
package sha1h_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned NUM_CHAIN  = 5;
    localparam int unsigned SCHED_LEN  = 16;
    localparam int unsigned TOTAL_W    = 61;

    localparam logic [WORD_W-1:0] H0_INIT = 32'h67452301;
    localparam logic [WORD_W-1:0] H1_INIT = 32'hefcdab89;
    localparam logic [WORD_W-1:0] H2_INIT = 32'h98badcfe;
    localparam logic [WORD_W-1:0] H3_INIT = 32'h10325476;
    localparam logic [WORD_W-1:0] H4_INIT = 32'hc3d2e1f0;

    localparam logic [WORD_W-1:0] K_00_19 = 32'h5a827999;
    localparam logic [WORD_W-1:0] K_20_39 = 32'h6ed9eba1;
    localparam logic [WORD_W-1:0] K_40_59 = 32'h8f1bbcdc;
    localparam logic [WORD_W-1:0] K_60_79 = 32'hca62c1d6;

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [2:0] WORD_LAST  = 3'd4;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_APPEND     = 2'd0,
        ACT_APPEND_FIN = 2'd1,
        ACT_FINISH     = 2'd2,
        ACT_NONE       = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        SRC_DATA = 2'd0,
        SRC_MARK = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } byte_src_t;

    typedef struct packed {
        logic      wr_byte;
        byte_src_t byte_src;
        logic      load_work;
        logic      round;
        logic      chain_add;
        logic      word_next;
        logic      clear;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic       last_round;
        logic       word_last;
    } dp_status_t;

endpackage

// File: hdl/sha1h_ctrl.sv
// Sequencing state machine: byte intake, padding, compression and digest output.
module sha1h_ctrl
    import sha1h_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_LOAD  = 6'b000100,
        S_ROUND = 6'b001000,
        S_ADD   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   fin_reg, fin_next;
    logic   marker_reg, marker_next;
    logic   len_ok_reg, len_ok_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fin_reg    <= 1'b0;
            marker_reg <= 1'b0;
            len_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fin_reg    <= fin_next;
            marker_reg <= marker_next;
            len_ok_reg <= len_ok_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        fin_next    = fin_reg;
        marker_next = marker_reg;
        len_ok_next = len_ok_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd         = '0;
        cmd.byte_src = SRC_ZERO;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (action_t'(action))
                        ACT_APPEND, ACT_APPEND_FIN:
                        begin
                            cmd.wr_byte  = 1'b1;
                            cmd.byte_src = SRC_DATA;
                            fin_next     = (action_t'(action) == ACT_APPEND_FIN);
                            marker_next  = 1'b0;
                            len_ok_next  = 1'b0;
                            if (status.fill == FILL_LAST)
                                state_next = S_LOAD;
                            else if (action_t'(action) == ACT_APPEND_FIN)
                                state_next = S_PAD;
                        end
                        ACT_FINISH:
                        begin
                            fin_next    = 1'b1;
                            marker_next = 1'b0;
                            len_ok_next = 1'b0;
                            state_next  = S_PAD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PAD:
            begin
                cmd.wr_byte = 1'b1;
                if (!marker_reg)
                begin
                    cmd.byte_src = SRC_MARK;
                    marker_next  = 1'b1;
                    if (status.fill < LEN_START)
                        len_ok_next = 1'b1;
                end
                else if (len_ok_reg && status.fill >= LEN_START)
                    cmd.byte_src = SRC_LEN;
                else
                    cmd.byte_src = SRC_ZERO;
                if (status.fill == FILL_LAST)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_work = 1'b1;
                state_next    = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                if (status.last_round)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.chain_add = 1'b1;
                if (!fin_reg)
                    state_next = S_IDLE;
                else if (len_ok_reg)
                    state_next = S_OUT;
                else
                begin
                    len_ok_next = 1'b1;
                    state_next  = S_PAD;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.word_next = 1'b1;
                    if (status.word_last)
                    begin
                        cmd.clear  = 1'b1;
                        fin_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/sha1h_dp.sv
// Datapath: block words, rolling schedule, round unit, chain value and counters.
module sha1h_dp
    import sha1h_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          data_byte,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    output logic [WORD_W-1:0]   digest_word,
    output logic [2:0]          word_index,
    output logic                last_word
);

    logic [WORD_W-1:0]  w_reg [SCHED_LEN];
    logic [WORD_W-1:0]  chain_reg [NUM_CHAIN];
    logic [WORD_W-1:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]         t_reg;
    logic [5:0]         fill_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [2:0]         widx_reg;

    logic [63:0]        len_bits;
    logic [7:0]         len_byte;
    logic [7:0]         byte_val;
    logic [4:0]         lane_off;
    logic [WORD_W-1:0]  sched_mix;
    logic [WORD_W-1:0]  w_new;
    logic [WORD_W-1:0]  f_val;
    logic [WORD_W-1:0]  k_val;
    logic [WORD_W-1:0]  tmp_val;

    assign len_bits = {total_reg, 3'b000};
    assign len_byte = len_bits[{~fill_reg[2:0], 3'b000} +: 8];
    assign lane_off = {~fill_reg[1:0], 3'b000};

    always_comb
    begin
        case (cmd.byte_src)
            SRC_DATA: byte_val = data_byte;
            SRC_MARK: byte_val = PAD_MARKER;
            SRC_LEN:  byte_val = len_byte;
            default:  byte_val = 8'h00;
        endcase
    end

    assign sched_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign w_new     = {sched_mix[WORD_W-2:0], sched_mix[WORD_W-1]};

    always_comb
    begin
        if (t_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_00_19;
        end
        else if (t_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_20_39;
        end
        else if (t_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_40_59;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_60_79;
        end
    end

    assign tmp_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_reg[0];

    // block words double as the rolling schedule during the rounds
    always_ff @(posedge clk)
    begin
        if (cmd.round)
        begin
            for (int i = 0; i < SCHED_LEN - 1; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[SCHED_LEN-1] <= w_new;
        end
        else if (cmd.wr_byte)
            w_reg[fill_reg[5:2]][lane_off +: 8] <= byte_val;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (cmd.round)
        begin
            a_reg <= tmp_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_reg <= '0;
        else if (cmd.load_work)
            t_reg <= '0;
        else if (cmd.round)
            t_reg <= t_reg + 7'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= H0_INIT;
            chain_reg[1] <= H1_INIT;
            chain_reg[2] <= H2_INIT;
            chain_reg[3] <= H3_INIT;
            chain_reg[4] <= H4_INIT;
            fill_reg     <= '0;
            total_reg    <= '0;
            widx_reg     <= '0;
        end
        else if (cmd.clear)
        begin
            chain_reg[0] <= H0_INIT;
            chain_reg[1] <= H1_INIT;
            chain_reg[2] <= H2_INIT;
            chain_reg[3] <= H3_INIT;
            chain_reg[4] <= H4_INIT;
            fill_reg     <= '0;
            total_reg    <= '0;
            widx_reg     <= '0;
        end
        else
        begin
            if (cmd.chain_add)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
            end
            if (cmd.wr_byte)
                fill_reg <= fill_reg + 6'd1;
            if (cmd.wr_byte && cmd.byte_src == SRC_DATA && total_reg != TOTAL_MAX)
                total_reg <= total_reg + {{(TOTAL_W-1){1'b0}}, 1'b1};
            if (cmd.word_next)
                widx_reg <= widx_reg + 3'd1;
        end
    end

    assign status.fill       = fill_reg;
    assign status.last_round = (t_reg == ROUND_LAST);
    assign status.word_last  = (widx_reg == WORD_LAST);

    assign digest_word = chain_reg[widx_reg];
    assign word_index  = widx_reg;
    assign last_word   = (widx_reg == WORD_LAST);

endmodule

// File: hdl/sha1_byte_stream_hasher_top.sv
// Top level of the SHA-1 byte stream hasher.
// Input channel (in_valid/in_ready): one beat carries action and data_byte.
//   action 0 appends data_byte, 1 appends it and finishes, 2 finishes with
//   no byte, 3 is dropped with no effect.
// Output channel (out_valid/out_ready): five beats per finished message,
//   digest_word H0..H4 with word_index 0..4, last_word high on H4.
// Compression: the beat that completes a 64-byte block is followed by the
//   compression (load, 80 rounds, chain add) in the single shared round unit.
// A finish writes the padding one byte per cycle up to the block end, then
//   compresses it, and pads and compresses one more block when the length
//   field does not fit in the first; then the five digest beats follow.
// in_ready is low from the end of a block until the compression is done and
//   from a finish until the last digest beat is taken.
// A stalled receiver holds the current digest beat; nothing is lost and the
//   input stays blocked until H4 is taken, after which the chain value,
//   byte count and fill return to their initial values.
// Reset (rst_n low, asynchronous) loads the initial chain value, clears
//   the counters and returns the block to idle.
module sha1_byte_stream_hasher_top
    import sha1h_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        action,
    input  logic [7:0]        data_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] digest_word,
    output logic [2:0]        word_index,
    output logic              last_word
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sha1h_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sha1h_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .status      (status),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule
